@@ design/q248_pkg.sv @@
// Shared types, constants and helpers for the Q24.8 fixed-point ALU.
// Used by every module of the design; depends on nothing.
package q248_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DATA_W    = 32;
  // Dividend |a| << (FRAC_BITS+1): one extra quotient bit for rounding
  localparam int unsigned DIV_W     = DATA_W + FRAC_BITS + 1;
  // front stage + one cell per quotient bit + output stage
  localparam int unsigned LATENCY   = DIV_W + 2;

  typedef enum logic [3:0] {
    MODE_ADD  = 4'd0,
    MODE_SUB  = 4'd1,
    MODE_MUL  = 4'd2,
    MODE_DIV  = 4'd3,
    MODE_MIN  = 4'd4,
    MODE_MAX  = 4'd5,
    MODE_INC  = 4'd6,
    MODE_DEC  = 4'd7,
    MODE_TOI  = 4'd8,
    MODE_FRI  = 4'd9
  } mode_e;

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     a_less;
    logic                     a_greater;
    logic                     a_equal;
    logic                     divide_by_zero;
    logic                     overflow;
  } out_word_t;

  // Front stage output: product still unrounded
  typedef struct packed {
    logic                     valid;
    logic                     is_div;
    logic                     is_mul;
    logic                     neg;
    logic                     dz;
    logic                     ovf;
    logic [DATA_W-1:0]        res;
    logic                     less;
    logic                     greater;
    logic                     equal;
    logic [2*DATA_W-1:0]      prod;
    logic [DATA_W-1:0]        den;
    logic [DIV_W-1:0]         dvd;
  } front_t;

  // Word travelling down the divider cells
  typedef struct packed {
    logic                     valid;
    logic                     is_div;
    logic                     neg;
    logic                     dz;
    logic                     ovf;
    logic [DATA_W-1:0]        res;
    logic                     less;
    logic                     greater;
    logic                     equal;
    logic [DATA_W-1:0]        den;
    logic [DATA_W-1:0]        rem;
    logic [DIV_W-1:0]         shr;   // dividend bits out, quotient bits in
  } cell_t;

  // Saturate a wide signed value to 32 bits: {overflow, result}
  function automatic logic [DATA_W:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = {1'b1, hi[DATA_W-1:0]};
    end else if (v < lo) begin
      sat32 = {1'b1, lo[DATA_W-1:0]};
    end else begin
      sat32 = {1'b0, v[DATA_W-1:0]};
    end
  endfunction

endpackage

@@ design/q248_front.sv @@
// Front stage: decodes the word, does every operation but multiply and divide,
// the 32x32 magnitude product and the divider setup. Uses q248_pkg.
module q248_front
  import q248_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     take_i,
  input  in_word_t op_i,
  output front_t   front_o
);

  logic signed [63:0] a64, b64, val;
  logic [DATA_W-1:0]  mag_a, mag_b;
  logic [DATA_W:0]    sat;
  logic               use_sat;
  front_t             d;
  front_t             q;
  logic               valid_q;

  // Operand decode and simple operations
  always_comb begin
    a64     = {{32{op_i.operand_a[DATA_W-1]}}, op_i.operand_a};
    b64     = {{32{op_i.operand_b[DATA_W-1]}}, op_i.operand_b};
    mag_a   = op_i.operand_a[DATA_W-1] ? (~op_i.operand_a + 1'b1) : op_i.operand_a;
    mag_b   = op_i.operand_b[DATA_W-1] ? (~op_i.operand_b + 1'b1) : op_i.operand_b;
    val     = '0;
    use_sat = 1'b0;
    d       = '0;
    d.valid = take_i;
    unique case (op_i.mode)
      MODE_ADD: begin val = a64 + b64;           use_sat = 1'b1; end
      MODE_SUB: begin val = a64 - b64;           use_sat = 1'b1; end
      MODE_INC: begin val = a64 + 64'sd1;        use_sat = 1'b1; end
      MODE_DEC: begin val = a64 - 64'sd1;        use_sat = 1'b1; end
      MODE_FRI: begin val = a64 <<< FRAC_BITS;   use_sat = 1'b1; end
      MODE_MIN: val = (a64 < b64) ? a64 : b64;
      MODE_MAX: val = (a64 > b64) ? a64 : b64;
      MODE_TOI: val = a64 >>> FRAC_BITS;
      MODE_MUL: d.is_mul = 1'b1;
      MODE_DIV: d.is_div = 1'b1;
      default:  val = '0;
    endcase
    sat     = sat32(val);
    d.res   = use_sat ? sat[DATA_W-1:0] : val[DATA_W-1:0];
    d.ovf   = use_sat & sat[DATA_W];
    d.neg   = op_i.operand_a[DATA_W-1] ^ op_i.operand_b[DATA_W-1];
    d.dz    = (op_i.operand_b == '0);
    d.less    = (a64 < b64);
    d.greater = (a64 > b64);
    d.equal   = (a64 == b64);
    d.prod  = mag_a * mag_b;
    d.den   = mag_b;
    d.dvd   = {mag_a, {(FRAC_BITS+1){1'b0}}};
  end

  // Stage register: valid cleared on reset, payload free-running
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    q <= d;
  end

  always_comb begin
    front_o       = q;
    front_o.valid = valid_q;
  end

endmodule

@@ design/q248_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per word and
// hands the word to the next cell. Uses q248_pkg.
module q248_div_cell
  import q248_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t cell_i,
  output cell_t cell_o
);

  logic [DATA_W-1:0] trial;
  logic              ge;
  cell_t             d;
  cell_t             q;
  logic              valid_q;

  // Shift in next dividend bit, compare, subtract
  always_comb begin
    trial = {cell_i.rem[DATA_W-2:0], cell_i.shr[DIV_W-1]};
    ge    = (trial >= cell_i.den);
    d     = cell_i;
    d.rem = ge ? (trial - cell_i.den) : trial;
    d.shr = {cell_i.shr[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    q <= d;
  end

  always_comb begin
    cell_o       = q;
    cell_o.valid = valid_q;
  end

endmodule

@@ design/fixed_point_q24_8_alu_core.sv @@
// Q24.8 fixed-point ALU top level: front stage, chain of divider cells,
// output register. Uses q248_pkg, q248_front and q248_div_cell.
// Every mode passes through the same stages: 1 front, 41 divider cells, 1 output.
// Throughput: one word per cycle; busy is never raised.
// Reset (rst_ni low, asynchronous) clears the valid bits of every stage.
// done_o marks each result for one cycle; the receiver cannot stall.
module fixed_point_q24_8_alu_core
  import q248_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  op_i,
  output logic      done_o,
  output out_word_t res_o
);

  front_t             front;
  cell_t              head;
  cell_t              chain [DIV_W+1];
  logic [DIV_W:0]     rnd;
  logic [63:0]        mul_r;
  logic signed [63:0] mul_s, div_s;
  logic [DATA_W:0]    mul_sat, div_sat;
  out_word_t          out_d, out_q;
  logic               done_q;

  assign busy = 1'b0;

  q248_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (start & ~busy),
    .op_i    (op_i),
    .front_o (front)
  );

  // Round and saturate the product, set up the first cell
  always_comb begin
    mul_r = (front.prod + 64'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
    mul_s = front.neg ? -$signed(mul_r) : $signed(mul_r);
    mul_sat = sat32(mul_s);
    head.valid   = front.valid;
    head.is_div  = front.is_div;
    head.neg     = front.neg;
    head.dz      = front.dz;
    head.ovf     = front.is_mul ? mul_sat[DATA_W] : front.ovf;
    head.res     = front.is_mul ? mul_sat[DATA_W-1:0] : front.res;
    head.less    = front.less;
    head.greater = front.greater;
    head.equal   = front.equal;
    head.den     = front.den;
    head.rem     = '0;
    head.shr     = front.dvd;
  end

  assign chain[0] = head;

  // Divider cell chain
  for (genvar i = 0; i < DIV_W; i++) begin : g_cell
    q248_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // Quotient has one extra bit: round half away, then saturate
  always_comb begin
    rnd   = ({1'b0, chain[DIV_W].shr} + 1'b1) >> 1;
    div_s = chain[DIV_W].neg ? -$signed(64'(rnd)) : $signed(64'(rnd));
    div_sat = sat32(div_s);
    out_d.a_less    = chain[DIV_W].less;
    out_d.a_greater = chain[DIV_W].greater;
    out_d.a_equal   = chain[DIV_W].equal;
    if (chain[DIV_W].is_div) begin
      out_d.divide_by_zero = chain[DIV_W].dz;
      out_d.overflow       = chain[DIV_W].dz ? 1'b0 : div_sat[DATA_W];
      out_d.result         = chain[DIV_W].dz ? '0 : div_sat[DATA_W-1:0];
    end else begin
      out_d.divide_by_zero = 1'b0;
      out_d.overflow       = chain[DIV_W].ovf;
      out_d.result         = chain[DIV_W].res;
    end
  end

  // Output register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[DIV_W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign res_o  = out_q;

  // Every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result missing after pipeline latency");

  // Exactly one compare flag per result
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot({res_o.a_less, res_o.a_greater, res_o.a_equal}))
    else $error("compare flags not one-hot");

  // Divide by zero gives zero and no overflow
  a_dz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.divide_by_zero) |-> (!res_o.overflow && res_o.result == '0))
    else $error("divide by zero result wrong");

endmodule

@@ test/fixed_point_q24_8_alu_core_checker.sv @@
// Checker for the Q24.8 ALU: predicts each accepted word and compares results.
// Depends on q248_pkg; watches the command and result ports of the block.
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_core_checker
  import q248_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  op_i,
  input  logic      done_o,
  input  out_word_t res_o,
  output int        fail_cnt,
  output int        pending_cnt,
  output int        result_cnt
);

  out_word_t alu_expected_q[$];

  // Saturate a wide value to 32 bits, noting overflow
  function automatic logic signed [31:0] clip32(input logic signed [65:0] v,
                                                inout logic ovf);
    if (v > 66'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Expected result for one command word
  function automatic out_word_t alu_predict(input in_word_t w);
    out_word_t          r;
    logic signed [65:0] a, b, s;
    logic        [65:0] ma, mb, q;
    logic               neg;
    logic               ovf;
    a = w.operand_a;
    b = w.operand_b;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    ovf = 1'b0;
    r = '0;
    case (w.mode)
      MODE_ADD: r.result = clip32(a + b, ovf);
      MODE_SUB: r.result = clip32(a - b, ovf);
      MODE_MUL: begin
        q = (ma * mb + 66'd128) >> FRAC_BITS;
        s = neg ? -$signed(q) : $signed(q);
        r.result = clip32(s, ovf);
      end
      MODE_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          q = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
          s = neg ? -$signed(q) : $signed(q);
          r.result = clip32(s, ovf);
        end
      end
      MODE_MIN: r.result = (a < b) ? a[31:0] : b[31:0];
      MODE_MAX: r.result = (a > b) ? a[31:0] : b[31:0];
      MODE_INC: r.result = clip32(a + 1, ovf);
      MODE_DEC: r.result = clip32(a - 1, ovf);
      MODE_TOI: r.result = w.operand_a >>> FRAC_BITS;
      MODE_FRI: r.result = clip32(a * 256, ovf);
      default:  r.result = '0;
    endcase
    r.overflow  = ovf;
    r.a_less    = a < b;
    r.a_greater = a > b;
    r.a_equal   = a == b;
    return r;
  endfunction

  assign pending_cnt = alu_expected_q.size();

  // Predict on accept, compare on strobe
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    if (!rst_ni) begin
      fail_cnt   <= 0;
      result_cnt <= 0;
    end else begin
      if (start && !busy) alu_expected_q.push_back(alu_predict(op_i));
      if (done_o) begin
        result_cnt <= result_cnt + 1;
        if (alu_expected_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, res_o);
          fail_cnt <= fail_cnt + 1;
        end else begin
          e = alu_expected_q.pop_front();
          if (e !== res_o) begin
            $display("%0t: mismatch expected res=%h lt=%b gt=%b eq=%b dz=%b ov=%b",
                     $time, e.result, e.a_less, e.a_greater, e.a_equal,
                     e.divide_by_zero, e.overflow);
            $display("%0t:          actual   res=%h lt=%b gt=%b eq=%b dz=%b ov=%b",
                     $time, res_o.result, res_o.a_less, res_o.a_greater,
                     res_o.a_equal, res_o.divide_by_zero, res_o.overflow);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/fixed_point_q24_8_alu_core_test.sv @@
// Testbench top for the Q24.8 ALU: clock, reset, command stimulus, verdict.
// Depends on q248_pkg, the block and fixed_point_q24_8_alu_core_checker.
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_core_test;
  import q248_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  op_i = '0;
  logic      done_o;
  out_word_t res_o;
  int        fail_cnt, pending_cnt, result_cnt;
  int        cycle_cnt = 0;
  int        word_cnt = 0;

  localparam int CYCLE_LIMIT = 200000;

  fixed_point_q24_8_alu_core dut (.*);
  fixed_point_q24_8_alu_core_checker chk (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("fixed_point_q24_8_alu_core verification failed");
      $finish;
    end
  end

  // Random operand with bias toward edges and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff - $urandom_range(0, 2);
      1: return 32'h80000000 + $urandom_range(0, 2);
      2: return $urandom_range(0, 3) - 1;
      3, 4: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      default: return $urandom;
    endcase
  endfunction

  // Issue one word, holding start until accepted
  task automatic send_word(input logic [3:0] m, input logic [31:0] a,
                           input logic [31:0] b);
    start <= 1'b1;
    op_i  <= '{mode: m, operand_a: a, operand_b: b};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    word_cnt++;
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  logic [31:0] edge_v [6] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1,
                              32'hffffffff, 32'h100};

  initial begin
    logic [3:0] m;
    int         lat_wait;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: every mode at the extremes, divide by zero, equal min/max
    for (int md = 0; md < 16; md++) begin
      send_word(md[3:0], edge_v[md % 6], edge_v[(md + 1) % 6]);
    end
    send_word(MODE_DIV, 32'h7fffffff, 32'h0);
    send_word(MODE_DIV, 32'h80000000, 32'h1);
    send_word(MODE_MUL, 32'h80000000, 32'h80000000);
    send_word(MODE_MUL, 32'hffffff80, 32'h1);
    send_word(MODE_MIN, 32'h55, 32'h55);
    send_word(MODE_MAX, 32'hffffff00, 32'hffffff00);
    send_word(MODE_TOI, 32'hffffff01, 32'h0);
    send_word(MODE_FRI, 32'h00800000, 32'h0);
    send_word(MODE_FRI, 32'hff7fffff, 32'h0);
    // Random part; last stretch runs without gaps
    for (int i = 0; i < 500; i++) begin
      m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      send_word(m, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'h0
                                                                : pick_operand());
      if (i < 400 && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    lat_wait = LATENCY + 4;
    repeat (lat_wait) @(posedge clk_i);
    $display("Sent %0d words over all sixteen mode codes, edge and random operands;",
             word_cnt);
    $display("%0d results checked field by field.", result_cnt);
    if (fail_cnt == 0) begin
      $display("fixed_point_q24_8_alu_core verification clean");
    end else begin
      $display("fixed_point_q24_8_alu_core verification failed");
    end
    $finish;
  end

endmodule
